// ----- hdl/sorted_priority_queue_macros.svh -----
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Clocked, reset-aware assertion helpers shared by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
// check that an expression holds at every clock edge out of reset
`define SPQ_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// check that a condition in one cycle implies a result in the next
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPQ_ASSERT(lbl, expr, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared widths, codes and the command word broadcast to every queue cell.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // default sizes
  localparam int unsigned DepthDefault     = 16;
  localparam int unsigned DataWidthDefault = 32;

  // fixed field widths
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned PrioWidth   = 16;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned FillWidth   = 5;

  typedef enum logic {
    ActInsert = 1'b0,
    ActRemove = 1'b1
  } spq_action_e;

  typedef enum logic [StatusWidth-1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } spq_status_e;

  // command seen by all cells in one cycle
  typedef struct packed {
    logic                        ins;
    logic                        rem;
    logic signed [PrioWidth-1:0] prio;
  } spq_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: keeps, loads the new entry, or shifts from
// a neighbor, deciding on insert from its own compare and its left neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
  parameter int unsigned DATA_WIDTH = spq_pkg::DataWidthDefault
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  spq_pkg::spq_cmd_t                      cmd_i,
  input  wire [DATA_WIDTH-1:0]                   new_value_i,
  input  wire                                    left_valid_i,
  input  wire                                    left_keep_i,
  input  wire [DATA_WIDTH-1:0]                   left_value_i,
  input  wire signed [spq_pkg::PrioWidth-1:0]    left_prio_i,
  input  wire                                    right_valid_i,
  input  wire [DATA_WIDTH-1:0]                   right_value_i,
  input  wire signed [spq_pkg::PrioWidth-1:0]    right_prio_i,
  output logic                                   valid_o,
  output logic                                   keep_o,
  output logic [DATA_WIDTH-1:0]                  value_o,
  output logic signed [spq_pkg::PrioWidth-1:0]   prio_o
);

  logic                                 valid_q, valid_d;
  logic [DATA_WIDTH-1:0]                value_q, value_d;
  logic signed [spq_pkg::PrioWidth-1:0] prio_q, prio_d;
  logic                                 keep;

  // entry stays in place on insert when it is not above the new priority
  assign keep = valid_q && ($signed(prio_q) <= $signed(cmd_i.prio));

  // choose next slot contents
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    prio_d  = prio_q;
    if (cmd_i.ins) begin
      valid_d = valid_q | left_valid_i;
      if (!keep) begin
        if (left_keep_i) begin
          value_d = new_value_i;
          prio_d  = cmd_i.prio;
        end else begin
          value_d = left_value_i;
          prio_d  = left_prio_i;
        end
      end
    end else if (cmd_i.rem) begin
      valid_d = right_valid_i;
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  // hold slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // hold slot payload
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign valid_o = valid_q;
  assign keep_o  = keep;
  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

`default_nettype wire

// ----- hdl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue
// Stable priority queue built as a chain of DEPTH compare-and-shift cells.
// ----------------------------------------------------------------------------
// The queue takes one word per clock cycle and returns one result word per
// input word, registered in the cycle after acceptance. Every cell compares its
// own priority with the incoming one in parallel and shifts by at most one
// slot, so an insert or a remove takes the same time no matter how
// full the queue is; input stalls only while the result register is held by
// a stalled output. Lowest priority leaves first; equal priorities leave in
// arrival order. An insert into a full queue is dropped with a full status.
`default_nettype none

`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
  parameter int unsigned DEPTH      = spq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = spq_pkg::DataWidthDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] in_value, [47:32] in_priority
  input  wire  [47:0] s_axis_tdata,
  // [0] action
  input  wire         s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [31:0] out_value, [47:32] out_priority, [49:48] status,
  // [54:50] fill_level, [55] zero
  output logic [55:0] m_axis_tdata
);

  localparam int unsigned CountWidth = $clog2(DEPTH + 1);
  localparam int unsigned PW         = spq_pkg::PrioWidth;

  logic                      in_accept;
  logic                      is_remove;
  logic                      full, empty;
  logic [CountWidth-1:0]     count_q, count_d;
  spq_pkg::spq_cmd_t         cmd;
  logic [DATA_WIDTH-1:0]     new_value;

  logic [DEPTH-1:0]          cell_valid;
  logic [DEPTH-1:0]          cell_keep;
  logic [DATA_WIDTH-1:0]     cell_value [DEPTH];
  logic signed [PW-1:0]      cell_prio  [DEPTH];

  logic                      out_valid_q;
  logic [spq_pkg::ValueWidth-1:0]  out_value_q, out_value_d;
  logic signed [PW-1:0]            out_prio_q, out_prio_d;
  spq_pkg::spq_status_e            out_status_q, out_status_d;
  logic [spq_pkg::FillWidth-1:0]   out_fill_q;

  // take a word when the result register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign is_remove     = (s_axis_tuser == spq_pkg::ActRemove);

  assign full  = (count_q == CountWidth'(DEPTH));
  assign empty = (count_q == '0);

  // broadcast command to the chain
  assign cmd.ins   = in_accept && !is_remove && !full;
  assign cmd.rem   = in_accept && is_remove && !empty;
  assign cmd.prio  = s_axis_tdata[47:32];
  assign new_value = DATA_WIDTH'(s_axis_tdata[31:0]);

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  left_valid, left_keep, right_valid;
    logic [DATA_WIDTH-1:0] left_value, right_value;
    logic signed [PW-1:0]  left_prio, right_prio;

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
      assign left_keep  = 1'b1;
      assign left_value = '0;
      assign left_prio  = '0;
    end else begin : g_body
      assign left_valid = cell_valid[i-1];
      assign left_keep  = cell_keep[i-1];
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_value = '0;
      assign right_prio  = '0;
    end else begin : g_mid
      assign right_valid = cell_valid[i+1];
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .new_value_i   (new_value),
      .left_valid_i  (left_valid),
      .left_keep_i   (left_keep),
      .left_value_i  (left_value),
      .left_prio_i   (left_prio),
      .right_valid_i (right_valid),
      .right_value_i (right_value),
      .right_prio_i  (right_prio),
      .valid_o       (cell_valid[i]),
      .keep_o        (cell_keep[i]),
      .value_o       (cell_value[i]),
      .prio_o        (cell_prio[i])
    );
  end

  // advance fill count
  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CountWidth'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CountWidth'(1);
    end
  end

  // form result fields
  always_comb begin
    out_value_d  = '0;
    out_prio_d   = '0;
    out_status_d = spq_pkg::StatusOk;
    if (is_remove) begin
      if (empty) begin
        out_status_d = spq_pkg::StatusEmpty;
      end else begin
        out_value_d = spq_pkg::ValueWidth'(cell_value[0]);
        out_prio_d  = cell_prio[0];
      end
    end else if (full) begin
      out_status_d = spq_pkg::StatusFull;
    end
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // load result word on accept
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_value_q  <= out_value_d;
      out_prio_q   <= out_prio_d;
      out_status_q <= out_status_d;
      out_fill_q   <= spq_pkg::FillWidth'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_fill_q, out_status_q, out_prio_q, out_value_q};

  `SPQ_ASSERT(a_count_matches_cells, $countones(cell_valid) == 32'(count_q), "fill count disagrees with occupied cells")
  `SPQ_ASSERT(a_cells_packed, $onehot0(cell_valid ^ (cell_valid >> 1)), "occupied cells are not a contiguous head run")
  `SPQ_ASSERT(a_head_sorted, !cell_valid[1] || ($signed(cell_prio[0]) <= $signed(cell_prio[1])), "head cell out of order")
  `SPQ_ASSERT_NEXT(a_full_drop, in_accept && !is_remove && full, out_status_q == spq_pkg::StatusFull && count_q == CountWidth'(DEPTH), "insert on full queue not reported or not dropped")

endmodule

`default_nettype wire

// ----- bench/sorted_priority_queue_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Watches both stream channels, predicts every result word from a software
// copy of the queue and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_priority_queue_checker #(
  parameter int unsigned DEPTH      = spq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = spq_pkg::DataWidthDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  // [31:0] in_value, [47:32] in_priority
  input  wire  [47:0] s_axis_tdata,
  // [0] action
  input  wire         s_axis_tuser,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  // [31:0] out_value, [47:32] out_priority, [49:48] status,
  // [54:50] fill_level, [55] zero
  input  wire  [55:0] m_axis_tdata,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  typedef struct {
    logic [DATA_WIDTH-1:0]                value;
    logic signed [spq_pkg::PrioWidth-1:0] prio;
  } queue_entry_t;

  // same layout as the result word below bit 55
  typedef struct packed {
    logic [spq_pkg::FillWidth-1:0]  fill;
    spq_pkg::spq_status_e           status;
    logic [spq_pkg::PrioWidth-1:0]  prio;
    logic [spq_pkg::ValueWidth-1:0] value;
  } result_word_t;

  queue_entry_t held_entries[$];
  result_word_t expected_words[$];
  int           mismatches = 0;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Apply one accepted word to the queue copy and return the result it owes.
  function automatic result_word_t apply_word(spq_pkg::spq_action_e act,
                                              logic [31:0] value,
                                              logic signed [spq_pkg::PrioWidth-1:0] prio);
    result_word_t res;
    queue_entry_t ent;
    int           slot;
    res = '0;
    res.status = spq_pkg::StatusOk;
    if (act == spq_pkg::ActInsert) begin
      if (held_entries.size() >= DEPTH) begin
        res.status = spq_pkg::StatusFull;
      end else begin
        ent.value = DATA_WIDTH'(value);
        ent.prio  = prio;
        // go behind every entry of lower or equal priority
        slot = 0;
        while (slot < held_entries.size() && held_entries[slot].prio <= prio) slot++;
        held_entries.insert(slot, ent);
      end
    end else begin
      if (held_entries.size() == 0) begin
        res.status = spq_pkg::StatusEmpty;
      end else begin
        ent = held_entries.pop_front();
        res.value = spq_pkg::ValueWidth'(ent.value);
        res.prio  = ent.prio;
      end
    end
    res.fill = spq_pkg::FillWidth'(held_entries.size());
    return res;
  endfunction

  always @(posedge clk_i) begin : track
    result_word_t want;
    result_word_t got;
    if (rst_ni) begin
      // compare an outgoing word with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[54:0];
        if (expected_words.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none, actual %0h",
                   $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("out_value", want.value, got.value);
          check_field("out_priority", 32'(want.prio), 32'(got.prio));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("fill_level", 32'(want.fill), 32'(got.fill));
          check_field("pad bit", 32'd0, 32'(m_axis_tdata[55]));
        end
      end
      // predict the result of an accepted input word
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words.push_back(apply_word(spq_pkg::spq_action_e'(s_axis_tuser),
                                            s_axis_tdata[31:0], s_axis_tdata[47:32]));
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= expected_words.size();
  end

endmodule

// ----- bench/sorted_priority_queue_tb.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and remove words with random gaps and output stalls: a
// directed opening for empty, full, extreme and tied priorities, then random
// phases that sweep the fill level. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_priority_queue_tb;

  localparam int unsigned QueueDepth  = spq_pkg::DepthDefault;
  localparam int unsigned QueueWidth  = spq_pkg::DataWidthDefault;
  localparam int          RandomWords = 1800;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = spq_pkg::ActInsert;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  int          mismatch_count;
  int          pending_count;
  bit          steady_send   = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sorted_priority_queue #(
    .DEPTH     (QueueDepth),
    .DATA_WIDTH(QueueWidth)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  sorted_priority_queue_checker #(
    .DEPTH     (QueueDepth),
    .DATA_WIDTH(QueueWidth)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // priorities cluster near zero so ties are frequent
  function automatic logic signed [15:0] pick_prio();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return 16'($signed($urandom_range(0, 6)) - 3);
    if (roll < 8) return 16'($urandom);
    if (roll == 8) return 16'sh8000;
    return 16'sh7FFF;
  endfunction

  // Present one word, then hold it until the queue takes it.
  task automatic send_word(spq_pkg::spq_action_e act, logic [31:0] value,
                           logic signed [15:0] prio);
    int gap;
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {prio, value};
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending and hold until every result word has come back.
  task automatic drain_queue();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // output side: ready runs broken by random stalls
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    int sent;
    int phase_len;
    int insert_pct;
    bit paused;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty remove, extremes, ties, fill to full and overflow
    send_word(spq_pkg::ActRemove, 32'h1234_5678, 16'sh0001);
    send_word(spq_pkg::ActInsert, 32'hFFFF_FFFF, 16'sh7FFF);
    send_word(spq_pkg::ActInsert, 32'h0000_0000, 16'sh8000);
    send_word(spq_pkg::ActInsert, 32'hA5A5_A5A5, 16'sh0000);
    send_word(spq_pkg::ActInsert, 32'h5A5A_5A5A, 16'sh0000);
    send_word(spq_pkg::ActInsert, 32'h0000_0001, -16'sd1);
    for (int i = 0; i < QueueDepth - 5; i++) begin
      send_word(spq_pkg::ActInsert, 32'hC000_0000 + i, 16'sh0000);
    end
    send_word(spq_pkg::ActInsert, 32'hDEAD_BEEF, 16'sh8000);
    repeat (4) send_word(spq_pkg::ActRemove, 32'hFFFF_FFFF, 16'shFFFF);

    // random phases with a changing insert bias to sweep the fill level
    sent   = 0;
    paused = 1'b0;
    while (sent < RandomWords) begin
      phase_len   = $urandom_range(20, 120);
      steady_send = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0:       insert_pct = 15;
        1:       insert_pct = 50;
        2:       insert_pct = 70;
        default: insert_pct = 90;
      endcase
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 99) < insert_pct) begin
          send_word(spq_pkg::ActInsert, $urandom, pick_prio());
        end else begin
          send_word(spq_pkg::ActRemove, $urandom, 16'($urandom));
        end
      end
      sent += phase_len;
      if (!paused && sent > RandomWords / 2) begin
        drain_queue();
        paused = 1'b1;
      end
    end

    // let the last result words arrive, then a few quiet cycles
    drain_queue();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin
    #15_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
bench/sorted_priority_queue_checker.sv
bench/sorted_priority_queue_tb.sv
